// File: sv/sound_voice_allocator_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the voice allocator.
// ---------------------------------------------------------------------------
`ifndef SOUND_VOICE_ALLOCATOR_UNIT_ASSERT_SVH
`define SOUND_VOICE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SVALLOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SVALLOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/svalloc_pkg.sv
// ---------------------------------------------------------------------------
// svalloc_pkg
// Types and constants shared by the voice allocator modules.
// ---------------------------------------------------------------------------
package svalloc_pkg;

	localparam int NUM_VOICES_DEF = 32;
	localparam int ENT_W          = 10;
	localparam int ECH_W          = 3;
	localparam int TIME_W         = 31;
	localparam int IDX_W          = 5;
	localparam int LIFE_W         = 32;
	localparam logic signed [LIFE_W-1:0] LIFE_MAX = 32'sh7fff_ffff;
	localparam logic [ENT_W-1:0] PLAYER_RST = 10'd1;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_STREAM  = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef struct packed {
		logic              active;
		logic              streaming;
		logic [ENT_W-1:0]  entity;
		logic [ECH_W-1:0]  channel;
		logic [TIME_W-1:0] end_time;
	} voice_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_TGT_RD,
		ST_TGT_WR,
		ST_DONE
	} state_t;

endpackage

// File: sv/svalloc_voice_table.sv
// ---------------------------------------------------------------------------
// svalloc_voice_table
// Voice state memory, one read and one write port, registered read data.
// Per-entry valid flags make unwritten or cleared entries read as zero.
// ---------------------------------------------------------------------------
module svalloc_voice_table
	import svalloc_pkg::*;
#(
	parameter int NUM_VOICES = NUM_VOICES_DEF,
	parameter int AW         = $clog2(NUM_VOICES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr_all,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output voice_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  voice_t        wr_data
);

	voice_t                mem [NUM_VOICES];
	voice_t                rd_raw_q;
	logic [NUM_VOICES-1:0] vld_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr_all) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

// File: sv/sound_voice_allocator_unit.sv
// ---------------------------------------------------------------------------
// sound_voice_allocator_unit
// Voice-stealing allocator over a table of mixer voices kept in memory.
//
// channel   dir  width      contents
// s_axis    in   80 + 2     request (tdata), action (tuser)
// m_axis    out  8 + 1      voice index, stole flag (tdata), granted (tuser)
// cfg       in   10         player entity register
//
// Allocate: the scan reads one voice-table entry per cycle; a channel match
// ends the scan early, and the chosen voice, if any, is then written.
// Release writes the target entry, mark streaming reads it first; clear all and a bad target skip both.
// One request in flight; a new one is taken while the result waits on m_axis.
// Reset empties the table at once and sets the player entity to 1.
// ---------------------------------------------------------------------------
`include "sound_voice_allocator_unit_assert.svh"

module sound_voice_allocator_unit
	import svalloc_pkg::*;
#(
	parameter int NUM_VOICES = NUM_VOICES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ENT_W-1:0] cfg_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// entity[9:0], entity_channel[12:10], current_time[43:13],
	// end_time[74:44], target_voice[79:75]
	input  logic [79:0]      s_axis_tdata,
	// action[1:0]
	input  logic [1:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// voice_index[4:0], stole_active[5], zero pad [7:6]
	output logic [7:0]       m_axis_tdata,
	// granted[0]
	output logic [0:0]       m_axis_tuser
);

	localparam int AW = $clog2(NUM_VOICES);
	localparam int CW = $clog2(NUM_VOICES + 1);

	state_t              state_q, state_d;
	logic [ENT_W-1:0]    player_q;

	logic [ENT_W-1:0]    ent_q;
	logic [ECH_W-1:0]    ech_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   endt_q;
	logic [IDX_W-1:0]    tgt_q;
	action_t             act_q;

	logic [CW-1:0]       rd_cnt_q;
	logic                vld_s1;
	logic [AW-1:0]       idx_s1;
	logic                found_q;
	logic                picked_q;
	logic                pick_act_q;
	logic [AW-1:0]       pick_q;
	logic signed [LIFE_W-1:0] best_q;

	logic                res_grant_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic                res_stole_q;
	logic                m_valid_q;
	logic [IDX_W-1:0]    m_idx_q;
	logic                m_stole_q;
	logic                m_grant_q;

	logic                in_xfer;
	action_t             in_act;
	logic                in_tgt_oob;
	logic                tgt_oob;
	logic                scan_end;
	logic                out_free;

	logic                clr_all;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	voice_t              rd_data;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	voice_t              wr_data;

	logic                eval;
	logic                match;
	logic                prot;
	logic                take;
	logic signed [LIFE_W-1:0] life;

	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign in_act     = action_t'(s_axis_tuser);
	assign in_tgt_oob = 32'(s_axis_tdata[79:75]) >= 32'(NUM_VOICES);
	assign tgt_oob    = 32'(tgt_q) >= 32'(NUM_VOICES);
	assign out_free   = !m_valid_q || m_axis_tready;
	assign scan_end   = (found_q || (32'(rd_cnt_q) == 32'(NUM_VOICES))) && !vld_s1;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_stole_q, m_idx_q};
	assign m_axis_tuser  = m_grant_q;

	// scan evaluation of one entry
	assign life  = $signed({1'b0, rd_data.end_time}) - $signed({1'b0, now_q});
	assign eval  = vld_s1 && !found_q && !rd_data.streaming;
	assign match = eval && (ech_q != '0) && (rd_data.entity == ent_q)
		&& (rd_data.channel == ech_q);
	assign prot  = (rd_data.entity == player_q) && (ent_q != player_q) && rd_data.active;
	assign take  = match || (eval && !prot && (life < best_q));

	svalloc_voice_table #(
		.NUM_VOICES (NUM_VOICES),
		.AW         (AW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr_all (clr_all),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (in_act) inside
						ACT_ALLOC: state_d = ST_SCAN;
						ACT_CLEAR: state_d = ST_DONE;
						ACT_RELEASE, ACT_STREAM: begin
							if (in_tgt_oob) begin
								state_d = ST_DONE;
							end else if (in_act == ACT_STREAM) begin
								state_d = ST_TGT_RD;
							end else begin
								state_d = ST_TGT_WR;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = picked_q ? ST_WRITE : ST_DONE;
				end
			end
			ST_WRITE:  state_d = ST_DONE;
			ST_TGT_RD: state_d = ST_TGT_WR;
			ST_TGT_WR: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		clr_all = 1'b0;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			ST_IDLE: begin
				clr_all = in_xfer && (in_act == ACT_CLEAR);
			end
			ST_SCAN: begin
				rd_en   = !found_q && (32'(rd_cnt_q) < 32'(NUM_VOICES));
				rd_addr = rd_cnt_q[AW-1:0];
			end
			ST_WRITE: begin
				wr_en             = 1'b1;
				wr_addr           = pick_q;
				wr_data.active    = 1'b1;
				wr_data.streaming = 1'b0;
				wr_data.entity    = ent_q;
				wr_data.channel   = ech_q;
				wr_data.end_time  = endt_q;
			end
			ST_TGT_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(tgt_q);
			end
			ST_TGT_WR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(tgt_q);
				if (act_q == ACT_STREAM) begin
					wr_data           = rd_data;
					wr_data.streaming = 1'b1;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			player_q  <= PLAYER_RST;
			m_valid_q <= 1'b0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			picked_q  <= 1'b0;
			rd_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				player_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			vld_s1 <= rd_en && (state_q == ST_SCAN);
			if (in_xfer) begin
				rd_cnt_q <= '0;
				found_q  <= 1'b0;
				picked_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (rd_en) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (match) begin
					found_q <= 1'b1;
				end
				if (take) begin
					picked_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (in_xfer) begin
			act_q  <= in_act;
			ent_q  <= s_axis_tdata[9:0];
			ech_q  <= s_axis_tdata[12:10];
			now_q  <= s_axis_tdata[43:13];
			endt_q <= s_axis_tdata[74:44];
			tgt_q  <= s_axis_tdata[79:75];
			best_q <= LIFE_MAX;
			if (in_act == ACT_CLEAR) begin
				res_grant_q <= 1'b1;
				res_idx_q   <= '0;
				res_stole_q <= 1'b0;
			end else begin
				res_grant_q <= 1'b0;
				res_idx_q   <= (in_act == ACT_ALLOC) ? '0 : s_axis_tdata[79:75];
				res_stole_q <= 1'b0;
			end
		end
		if (state_q == ST_SCAN && take) begin
			best_q     <= life;
			pick_q     <= idx_s1;
			pick_act_q <= rd_data.active;
		end
		if (state_q == ST_WRITE) begin
			res_grant_q <= 1'b1;
			res_idx_q   <= IDX_W'(pick_q);
			res_stole_q <= pick_act_q;
		end
		if (state_q == ST_TGT_WR) begin
			res_grant_q <= 1'b1;
		end
		if (state_q == ST_DONE && out_free) begin
			m_grant_q <= res_grant_q;
			m_idx_q   <= res_idx_q;
			m_stole_q <= res_stole_q;
		end
	end

	`SVALLOC_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1,
		32'(rd_cnt_q) <= 32'(NUM_VOICES), "scan counter past table end")
	`SVALLOC_ASSERT_IMP(a_stop_on_match, clk, arst_n, found_q && state_q == ST_SCAN,
		!rd_en, "read issued after channel match")
	`SVALLOC_ASSERT_IMP(a_write_has_pick, clk, arst_n, state_q == ST_WRITE,
		picked_q && !tgt_oob || picked_q, "write-back without a chosen voice")
	`SVALLOC_ASSERT_NXT(a_alloc_scan, clk, arst_n,
		in_xfer && in_act == ACT_ALLOC,
		state_q == ST_SCAN && rd_cnt_q == '0, "allocate did not start a scan")

endmodule

// File: verif/sound_voice_allocator_unit_tb.sv
// ---------------------------------------------------------------------------
// sound_voice_allocator_unit_tb
// Drives request transfers into the voice allocator and checks every result
// transfer against a voice-table predictor kept in step with the design.
// A directed pass covers field extremes and the allocation rules. Random
// traffic runs under several player-entity settings and adds table
// saturation, player protection and streaming floods. Both stream sides
// idle at random, and the result side also holds off for long stretches.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module sound_voice_allocator_unit_tb;
	import svalloc_pkg::*;

	localparam int NUM_VOICES  = NUM_VOICES_DEF;
	localparam int IDLE_TAIL   = NUM_VOICES + 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 190;

	typedef struct packed {
		action_t           act;
		logic [ENT_W-1:0]  ent;
		logic [ECH_W-1:0]  ech;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] endt;
		logic [IDX_W-1:0]  tgt;
	} voice_req_t;

	typedef struct packed {
		logic             granted;
		logic [IDX_W-1:0] voice;
		logic             stole;
	} voice_grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [9:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	voice_req_t   req_q[$];
	voice_grant_t grant_q[$];

	logic              tab_active [NUM_VOICES];
	logic              tab_streaming [NUM_VOICES];
	logic [ENT_W-1:0]  tab_entity [NUM_VOICES];
	logic [ECH_W-1:0]  tab_channel [NUM_VOICES];
	logic [TIME_W-1:0] tab_end [NUM_VOICES];
	logic [ENT_W-1:0]  tab_player = PLAYER_RST;

	logic req_taken = 1'b0;
	logic res_taken = 1'b0;
	int   err_cnt = 0;
	int   cycle_cnt = 0;
	int   queued_cnt = 0;
	int   tx_gap = 0;
	int   rx_wait = 0;
	int   rx_cycle = 0;
	bit   tx_fast = 1'b0;
	bit   rx_fast = 1'b0;

	sound_voice_allocator_unit #(
		.NUM_VOICES(NUM_VOICES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_table();
		int i;
		for (i = 0; i < NUM_VOICES; i++) begin
			tab_active[i]    = 1'b0;
			tab_streaming[i] = 1'b0;
			tab_entity[i]    = '0;
			tab_channel[i]   = '0;
			tab_end[i]       = '0;
		end
	endfunction

	function automatic voice_grant_t apply_request(voice_req_t r);
		voice_grant_t g;
		logic signed [LIFE_W-1:0] best;
		logic signed [LIFE_W-1:0] life;
		int pick;
		int i;
		g = '0;
		best = LIFE_MAX;
		pick = -1;
		case (r.act)
			ACT_ALLOC: begin
				for (i = 0; i < NUM_VOICES; i++) begin
					if (tab_streaming[i])
						continue;
					if (r.ech != 0 && tab_entity[i] == r.ent && tab_channel[i] == r.ech) begin
						pick = i;
						break;
					end
					if (tab_entity[i] == tab_player && r.ent != tab_player && tab_active[i])
						continue;
					life = $signed({1'b0, tab_end[i]}) - $signed({1'b0, r.now});
					if (life < best) begin
						best = life;
						pick = i;
					end
				end
				if (pick >= 0) begin
					g.granted = 1'b1;
					g.voice = pick[IDX_W-1:0];
					g.stole = tab_active[pick];
					tab_active[pick]    = 1'b1;
					tab_streaming[pick] = 1'b0;
					tab_entity[pick]    = r.ent;
					tab_channel[pick]   = r.ech;
					tab_end[pick]       = r.endt;
				end
			end
			ACT_CLEAR: begin
				clear_table();
				g.granted = 1'b1;
			end
			default: begin
				g.voice = r.tgt;
				if (int'(r.tgt) < NUM_VOICES) begin
					g.granted = 1'b1;
					if (r.act == ACT_RELEASE) begin
						tab_active[r.tgt]  = 1'b0;
						tab_entity[r.tgt]  = '0;
						tab_channel[r.tgt] = '0;
						tab_end[r.tgt]     = '0;
					end
					tab_streaming[r.tgt] = (r.act == ACT_STREAM);
				end
			end
		endcase
		return g;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// request driver
	always @(negedge clk) begin
		voice_req_t r;
		if (arst_n && (!s_axis_tvalid || req_taken)) begin
			if (req_taken) begin
				if ($urandom_range(0, 39) == 0)
					tx_fast = !tx_fast;
				tx_gap = tx_fast ? 0 : $urandom_range(0, 9);
			end
			if (tx_gap > 0) begin
				tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (req_q.size() > 0) begin
				r = req_q.pop_front();
				s_axis_tdata  <= {r.tgt, r.endt, r.now, r.ech, r.ent};
				s_axis_tuser  <= r.act;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result ready, with long hold-off windows
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (res_taken) begin
				if ($urandom_range(0, 39) == 0)
					rx_fast = !rx_fast;
				rx_wait = rx_fast ? 0 : $urandom_range(0, 9);
			end
			if ((rx_cycle >= 6000 && rx_cycle < 6400) ||
			    (rx_cycle >= 30000 && rx_cycle < 30400)) begin
				m_axis_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor and predictor update
	always @(posedge clk) begin
		voice_grant_t want;
		req_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		res_taken <= arst_n && m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			cycle_cnt <= cycle_cnt + 1;
			if (cfg_we)
				tab_player = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				if (grant_q.size() == 0) begin
					$display("%0t ns: result transfer, expected none, actual granted %0d voice %0d",
						$time, m_axis_tuser[0], m_axis_tdata[4:0]);
					err_cnt++;
				end else begin
					want = grant_q.pop_front();
					check_field("granted", int'(want.granted), int'(m_axis_tuser[0]));
					check_field("voice_index", int'(want.voice), int'(m_axis_tdata[4:0]));
					check_field("stole_active", int'(want.stole), int'(m_axis_tdata[5]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				grant_q.push_back(apply_request({action_t'(s_axis_tuser),
					s_axis_tdata[9:0], s_axis_tdata[12:10], s_axis_tdata[43:13],
					s_axis_tdata[74:44], s_axis_tdata[79:75]}));
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic push_req(action_t act, logic [ENT_W-1:0] ent, logic [ECH_W-1:0] ech,
			logic [TIME_W-1:0] now, logic [TIME_W-1:0] endt, logic [IDX_W-1:0] tgt);
		req_q.push_back({act, ent, ech, now, endt, tgt});
		queued_cnt++;
	endtask

	task automatic wait_idle();
		while (req_q.size() != 0 || s_axis_tvalid || grant_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic write_player(logic [ENT_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [ENT_W-1:0] rnd_ent();
		return ENT_W'($urandom());
	endfunction

	function automatic logic [ECH_W-1:0] rnd_ech();
		return ECH_W'($urandom());
	endfunction

	function automatic logic [TIME_W-1:0] rnd_time();
		return TIME_W'($urandom());
	endfunction

	function automatic logic [IDX_W-1:0] rnd_tgt();
		return IDX_W'($urandom());
	endfunction

	function automatic logic [ENT_W-1:0] pick_entity(logic [ENT_W-1:0] player);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			return player;
		if (roll < 75) begin
			case ($urandom_range(0, 4))
				0: return 10'd0;
				1: return 10'd1023;
				2: return 10'd2;
				3: return 10'd3;
				default: return 10'd4;
			endcase
		end
		return rnd_ent();
	endfunction

	task automatic push_phase(int count, logic [ENT_W-1:0] player);
		int start;
		int roll;
		int n;
		logic [TIME_W-1:0] now;
		logic [ENT_W-1:0] other;
		start = queued_cnt;
		while (queued_cnt - start < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				// ordinary sound traffic with a moving clock
				now = $urandom_range(0, 1) ? TIME_W'($urandom()) : TIME_W'($urandom_range(0, 100000));
				repeat ($urandom_range(8, 30)) begin
					now = now + TIME_W'($urandom_range(0, 4000));
					n = $urandom_range(0, 99);
					if (n < 78)
						push_req(ACT_ALLOC, pick_entity(player), ECH_W'($urandom_range(0, 7)), now,
							now + TIME_W'($urandom_range(0, 60000)) - TIME_W'(15000),
							rnd_tgt());
					else if (n < 90)
						push_req(ACT_RELEASE, rnd_ent(), rnd_ech(), rnd_time(), rnd_time(),
							rnd_tgt());
					else if (n < 98)
						push_req(ACT_STREAM, rnd_ent(), rnd_ech(), rnd_time(), rnd_time(),
							rnd_tgt());
					else
						push_req(ACT_CLEAR, rnd_ent(), rnd_ech(), rnd_time(), rnd_time(),
							rnd_tgt());
				end
			end else if (roll < 80) begin
				// voices ending at the far limit are never stolen by lifetime
				push_req(ACT_CLEAR, 0, 0, 0, 0, 0);
				repeat ($urandom_range(32, 34))
					push_req(ACT_ALLOC, pick_entity(player), 0, 0, '1, rnd_tgt());
				push_req(ACT_RELEASE, 0, 0, 0, 0, rnd_tgt());
				push_req(ACT_ALLOC, pick_entity(player), 0, 0, rnd_time(), 0);
			end else if (roll < 88) begin
				// table full of player voices, other entities refused
				push_req(ACT_CLEAR, 0, 0, 0, 0, 0);
				repeat (NUM_VOICES)
					push_req(ACT_ALLOC, player, 0, rnd_time(), rnd_time(), rnd_tgt());
				repeat (2) begin
					other = player + ENT_W'($urandom_range(1, 1023));
					push_req(ACT_ALLOC, other, rnd_ech(), rnd_time(), rnd_time(), rnd_tgt());
				end
				push_req(ACT_ALLOC, player, rnd_ech(), rnd_time(), rnd_time(), rnd_tgt());
			end else if (roll < 94) begin
				// streaming flood
				repeat ($urandom_range(20, 32))
					push_req(ACT_STREAM, rnd_ent(), rnd_ech(), rnd_time(), rnd_time(),
						rnd_tgt());
				repeat ($urandom_range(3, 6))
					push_req(ACT_ALLOC, pick_entity(player), rnd_ech(), rnd_time(), rnd_time(),
						rnd_tgt());
				repeat (8)
					push_req(ACT_RELEASE, rnd_ent(), rnd_ech(), rnd_time(), rnd_time(),
						rnd_tgt());
			end else begin
				repeat ($urandom_range(1, 6))
					push_req(action_t'($urandom_range(0, 3)), rnd_ent(), rnd_ech(),
						rnd_time(), rnd_time(), rnd_tgt());
			end
		end
	endtask

	initial begin
		logic [ENT_W-1:0] player_set [6];
		int k;
		clear_table();
		player_set = '{10'd0, 10'd1023, 10'd1, 10'd0, 10'd512, 10'd0};
		player_set[3] = rnd_ent();
		player_set[5] = rnd_ent();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_req(ACT_CLEAR, 0, 0, 0, 0, 0);
		push_req(ACT_ALLOC, 0, 0, 0, 0, 0);
		push_req(ACT_ALLOC, 1023, 7, '1, '1, '1);
		push_req(ACT_ALLOC, 1023, 7, 5, 100, 0);
		push_req(ACT_ALLOC, 1023, 0, 5, 200, 0);
		push_req(ACT_ALLOC, 1, 2, 0, 1000, 0);
		push_req(ACT_ALLOC, 1, 3, 0, 1000, 0);
		push_req(ACT_ALLOC, 300, 2, 0, 5, 0);
		push_req(ACT_ALLOC, 1, 2, 0, 50, 0);
		push_req(ACT_STREAM, 0, 0, 0, 0, 0);
		push_req(ACT_ALLOC, 5, 1, 0, 10, 0);
		push_req(ACT_RELEASE, 0, 0, 0, 0, 0);
		push_req(ACT_STREAM, 0, 0, 0, 0, 31);
		push_req(ACT_ALLOC, 6, 1, 0, 10, 0);
		push_req(ACT_RELEASE, 0, 0, 0, 0, 31);
		push_req(ACT_ALLOC, 7, 4, 2000, 10, 0);
		push_req(ACT_ALLOC, 8, 0, 0, '1, 0);
		push_req(ACT_ALLOC, 9, 5, '1, 0, 0);
		push_req(ACT_RELEASE, 1023, 7, '1, '1, 31);
		push_req(ACT_STREAM, 1023, 7, '1, '1, 31);
		push_req(ACT_ALLOC, 1023, 7, 0, 0, 0);
		push_req(ACT_CLEAR, 1023, 7, '1, '1, 31);
		push_req(ACT_ALLOC, 1, 1, 0, 0, 0);

		for (k = 0; k < 6; k++) begin
			write_player(player_set[k]);
			push_phase(PHASE_ITEMS, player_set[k]);
		end
		wait_idle();

		if (err_cnt == 0 && grant_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
